// ----- sv/conv2d_filter_bank_top_macros.svh -----
// Assertion macros shared by the filter bank RTL.
`ifndef CONV2D_FILTER_BANK_TOP_MACROS_SVH
`define CONV2D_FILTER_BANK_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define C2DFB_ASSERT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("c2dfb: same-cycle check failed");
`define C2DFB_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("c2dfb: next-cycle check failed");
`else
`define C2DFB_ASSERT(lbl, clk_s, rstn_s, ante, cons)
`define C2DFB_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

// ----- sv/c2dfb_pkg.sv -----
// Types and constants shared by the filter bank modules.
package c2dfb_pkg;

	localparam int PIX_W = 8;
	localparam int COEF_W = 16;
	localparam int RESP_W = 28;
	localparam int POS_W = 10;
	localparam int ROW_W = 10;
	localparam int CFG_W = 11;
	localparam int CFG_IDX_W = 2;
	localparam int STRIDE_W = 4;
	localparam int FILT_SEL_W = 2;
	localparam int TAP_SEL_W = 2;
	localparam int FILT_OUT_W = 2;
	localparam int FILT_IDX_W = 4;
	localparam int TAP_IDX_W = 6;
	localparam int MAX_HEIGHT = 1024;
	localparam int IMAGE_WIDTH_RESET = 1024;
	localparam int IMAGE_HEIGHT_RESET = 1024;
	localparam int STRIDE_RESET = 1;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 2'd2;

	localparam logic OP_COEF = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [RESP_W-1:0] resp_t;

	typedef enum logic [1:0] {
		TOK_NONE = 2'd0,
		TOK_FILT = 2'd1,
		TOK_COEF = 2'd2
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t kind;
		logic [FILT_IDX_W-1:0] filt;
		logic [TAP_IDX_W-1:0] tap;
		logic last;
	} tok_ctl_t;

endpackage

// ----- sv/c2dfb_if.sv -----
// Handshake interfaces for the input item channel and the result channel.
interface c2dfb_in_if;
	import c2dfb_pkg::*;
	logic valid;
	logic ready;
	logic op;
	logic [FILT_SEL_W-1:0] filter_sel;
	logic [TAP_SEL_W-1:0] tap_row;
	logic [TAP_SEL_W-1:0] tap_col;
	logic signed [COEF_W-1:0] coefficient;
	logic [PIX_W-1:0] pixel;

	modport source(output valid, output op, output filter_sel, output tap_row,
		output tap_col, output coefficient, output pixel, input ready);
	modport sink(input valid, input op, input filter_sel, input tap_row,
		input tap_col, input coefficient, input pixel, output ready);
endinterface

interface c2dfb_out_if;
	import c2dfb_pkg::*;
	logic valid;
	logic ready;
	logic [FILT_OUT_W-1:0] filter_index;
	logic [POS_W-1:0] out_row;
	logic [POS_W-1:0] out_col;
	logic signed [RESP_W-1:0] response;
	logic last;

	modport source(output valid, output filter_index, output out_row, output out_col,
		output response, output last, input ready);
	modport sink(input valid, input filter_index, input out_row, input out_col,
		input response, input last, output ready);
endinterface

// ----- sv/c2dfb_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module c2dfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ----- sv/c2dfb_cell.sv -----
// One tap cell of the systolic chain: holds its tap of every filter and adds its product.
module c2dfb_cell #(
	parameter int NUM_FILTERS = 4,
	parameter int TAP = 0,
	parameter int TAPS = 9
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input c2dfb_pkg::tok_ctl_t prev_ctl,
	input logic [TAPS*c2dfb_pkg::PIX_W-1:0] prev_win,
	input c2dfb_pkg::resp_t prev_psum,
	input logic [c2dfb_pkg::POS_W-1:0] prev_orow,
	input logic [c2dfb_pkg::POS_W-1:0] prev_ocol,
	input c2dfb_pkg::coef_t prev_coef,
	output c2dfb_pkg::tok_ctl_t next_ctl,
	output logic [TAPS*c2dfb_pkg::PIX_W-1:0] next_win,
	output c2dfb_pkg::resp_t next_psum,
	output logic [c2dfb_pkg::POS_W-1:0] next_orow,
	output logic [c2dfb_pkg::POS_W-1:0] next_ocol,
	output c2dfb_pkg::coef_t next_coef
);
	import c2dfb_pkg::*;

	localparam int FIW = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;

	coef_t coef_q [NUM_FILTERS];
	logic [FIW-1:0] fsel;
	logic [PIX_W-1:0] pix;
	coef_t tap_coef;
	logic signed [PIX_W+COEF_W:0] prod;
	resp_t sum;

	tok_ctl_t ctl_q;
	logic [TAPS*PIX_W-1:0] win_q;
	resp_t psum_q;
	logic [POS_W-1:0] orow_q;
	logic [POS_W-1:0] ocol_q;
	coef_t coefv_q;

	assign fsel = prev_ctl.filt[FIW-1:0];
	assign pix = prev_win[TAP*PIX_W +: PIX_W];
	assign tap_coef = coef_q[fsel];
	assign prod = $signed({1'b0, pix}) * tap_coef;
	assign sum = prev_psum + RESP_W'(prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int f = 0; f < NUM_FILTERS; f++) begin
				coef_q[f] <= '0;
			end
		end else if (en && prev_ctl.kind == TOK_COEF && prev_ctl.tap == TAP_IDX_W'(TAP)) begin
			coef_q[fsel] <= prev_coef;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '{kind: TOK_NONE, filt: '0, tap: '0, last: 1'b0};
		end else if (en) begin
			ctl_q <= prev_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			win_q <= prev_win;
			psum_q <= (prev_ctl.kind == TOK_FILT) ? sum : prev_psum;
			orow_q <= prev_orow;
			ocol_q <= prev_ocol;
			coefv_q <= prev_coef;
		end
	end

	assign next_ctl = ctl_q;
	assign next_win = win_q;
	assign next_psum = psum_q;
	assign next_orow = orow_q;
	assign next_ocol = ocol_q;
	assign next_coef = coefv_q;
endmodule

// ----- sv/conv2d_filter_bank_top.sv -----
// Top level of the strided 3x3 filter bank with line stores and a systolic tap chain.
//
// Channel   Dir  Handshake        Carries
// in_ch     in   valid/ready      op, filter_sel, tap_row, tap_col, coefficient, pixel
// out_ch    out  valid/ready      filter_index, out_row, out_col, response, last
// cfg       in   cfg_wr_en        cfg_index, cfg_data (no read-back)
//
// A coefficient item or a pixel that completes no window passes stage 2 as a single token.
// A pixel whose window lies on the stride grid sends one token per filter into the tap chain,
// while stage 1 can hold the next item; results leave through the tap cells and the output register.
// Reset clears the filter store, counters and control; the line store needs no clearing.
// A stalled result channel freezes the tap chain, and input stops once the front stages fill.
`include "conv2d_filter_bank_top_macros.svh"

module conv2d_filter_bank_top #(
	parameter int NUM_FILTERS = 4,
	parameter int FILTER_ROWS = 3,
	parameter int FILTER_COLS = 3,
	parameter int MAX_WIDTH = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [c2dfb_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [c2dfb_pkg::CFG_W-1:0] cfg_data,
	c2dfb_in_if.sink in_ch,
	c2dfb_out_if.source out_ch
);
	import c2dfb_pkg::*;

	localparam int TAPS = FILTER_ROWS * FILTER_COLS;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
	localparam int LINE_W = ((FILTER_ROWS > 1) ? FILTER_ROWS - 1 : 1) * PIX_W;
	localparam int FIW = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [STRIDE_W-1:0] stride_q;
	logic cfg_hit;
	logic [WW-1:0] wv;
	logic [WW-1:0] w_eff;
	logic [CFG_W-1:0] h_eff;
	logic [STRIDE_W-1:0] s_eff;

	logic [CW-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [STRIDE_W-1:0] col_ph_q;
	logic [STRIDE_W-1:0] row_ph_q;
	logic [POS_W-1:0] ocol_q;
	logic [POS_W-1:0] orow_q;
	logic col_last;
	logic row_last;
	logic col_in;
	logic row_in;
	logic col_wrap;
	logic row_wrap;
	logic emit;

	logic in_acc;
	logic pix_acc;
	logic adv;

	logic valid_s1;
	logic op_s1;
	logic [FILT_SEL_W-1:0] fsel_s1;
	logic [TAP_SEL_W-1:0] trow_s1;
	logic [TAP_SEL_W-1:0] tcol_s1;
	coef_t coef_s1;
	logic [PIX_W-1:0] pixel_s1;
	logic [CW-1:0] col_s1;
	logic emit_s1;
	logic [POS_W-1:0] orow_s1;
	logic [POS_W-1:0] ocol_s1;
	logic s1_go;
	logic coef_ok;
	logic [FILTER_ROWS*PIX_W-1:0] col_vec;

	logic valid_s2;
	tok_kind_t kind_s2;
	logic [FIW-1:0] filt_s2;
	logic [TAPS-1:0][PIX_W-1:0] win_s2;
	logic [POS_W-1:0] orow_s2;
	logic [POS_W-1:0] ocol_s2;
	logic [FILT_IDX_W-1:0] cfilt_s2;
	logic [TAP_IDX_W-1:0] ctap_s2;
	coef_t cval_s2;
	logic s2_last;
	logic s2_done;
	tok_ctl_t inj_ctl;

	tok_ctl_t ctl_c [TAPS+1];
	logic [TAPS*PIX_W-1:0] win_c [TAPS+1];
	resp_t psum_c [TAPS+1];
	logic [POS_W-1:0] orow_c [TAPS+1];
	logic [POS_W-1:0] ocol_c [TAPS+1];
	coef_t coefv_c [TAPS+1];

	logic out_valid_q;
	logic [FILT_OUT_W-1:0] out_filt_q;
	logic [POS_W-1:0] out_row_q;
	logic [POS_W-1:0] out_col_q;
	resp_t out_resp_q;
	logic out_last_q;

	// Configuration registers.
	assign cfg_hit = cfg_wr_en && (cfg_index == REG_IMAGE_WIDTH ||
		cfg_index == REG_IMAGE_HEIGHT || cfg_index == REG_STRIDE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CFG_W'(IMAGE_WIDTH_RESET);
			height_q <= CFG_W'(IMAGE_HEIGHT_RESET);
			stride_q <= STRIDE_W'(STRIDE_RESET);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: width_q <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				REG_STRIDE: stride_q <= cfg_data[STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	assign wv = WW'(width_q);

	always_comb begin
		if (wv == '0) begin
			w_eff = WW'(1);
		end else if (wv > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = wv;
		end
		if (height_q == '0) begin
			h_eff = CFG_W'(1);
		end else if (height_q > CFG_W'(MAX_HEIGHT)) begin
			h_eff = CFG_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
		s_eff = (stride_q == '0) ? STRIDE_W'(1) : stride_q;
	end

	// Raster position and stride phase counters.
	assign col_last = (WW'(col_q) + WW'(1)) >= w_eff;
	assign row_last = (CFG_W'(row_q) + CFG_W'(1)) >= h_eff;
	assign col_in = col_q >= CW'(FILTER_COLS - 1);
	assign row_in = row_q >= ROW_W'(FILTER_ROWS - 1);
	assign col_wrap = (col_ph_q + STRIDE_W'(1)) == s_eff;
	assign row_wrap = (row_ph_q + STRIDE_W'(1)) == s_eff;
	assign emit = col_in && row_in && col_ph_q == '0 && row_ph_q == '0;

	assign in_acc = in_ch.valid && in_ch.ready;
	assign pix_acc = in_acc && in_ch.op == OP_PIXEL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			col_ph_q <= '0;
			row_ph_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
			col_ph_q <= '0;
			row_ph_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (pix_acc) begin
			if (col_last) begin
				col_q <= '0;
				col_ph_q <= '0;
				ocol_q <= '0;
				if (row_last) begin
					row_q <= '0;
					row_ph_q <= '0;
					orow_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
					if (row_in) begin
						row_ph_q <= row_wrap ? '0 : row_ph_q + STRIDE_W'(1);
						orow_q <= orow_q + POS_W'(row_wrap);
					end
				end
			end else begin
				col_q <= col_q + CW'(1);
				if (col_in) begin
					col_ph_q <= col_wrap ? '0 : col_ph_q + STRIDE_W'(1);
					ocol_q <= ocol_q + POS_W'(col_wrap);
				end
			end
		end
	end

	// Stage 1: line store read in flight.
	assign in_ch.ready = !valid_s1 || s1_go;
	assign s1_go = valid_s1 && (!valid_s2 || s2_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1 <= in_ch.op;
			fsel_s1 <= in_ch.filter_sel;
			trow_s1 <= in_ch.tap_row;
			tcol_s1 <= in_ch.tap_col;
			coef_s1 <= in_ch.coefficient;
			pixel_s1 <= in_ch.pixel;
			col_s1 <= col_q;
			emit_s1 <= emit;
			orow_s1 <= orow_q;
			ocol_s1 <= ocol_q;
		end
	end

	generate
		if (FILTER_ROWS > 1) begin : g_line
			logic [LINE_W-1:0] rd_data;
			logic [LINE_W-1:0] line_rd;
			logic [LINE_W-1:0] wr_data;
			logic [LINE_W-1:0] byp_s1;
			logic hit_s1;
			logic wr_en;

			assign wr_en = s1_go && op_s1 == OP_PIXEL;
			assign line_rd = hit_s1 ? byp_s1 : rd_data;
			assign col_vec = {pixel_s1, line_rd};
			assign wr_data = col_vec[FILTER_ROWS*PIX_W-1:PIX_W];

			// The write of the leaving pixel lands in the cycle of this read.
			always_ff @(posedge clk) begin
				if (pix_acc) begin
					hit_s1 <= wr_en && col_s1 == col_q;
					byp_s1 <= wr_data;
				end
			end

			c2dfb_ram #(
				.WIDTH(LINE_W),
				.DEPTH(MAX_WIDTH)
			) u_line_ram (
				.clk(clk),
				.we(wr_en),
				.waddr(col_s1),
				.wdata(wr_data),
				.re(pix_acc),
				.raddr(col_q),
				.rdata(rd_data)
			);
		end else begin : g_no_line
			assign col_vec = pixel_s1;
		end
	endgenerate

	// Stage 2: window and filter sequencer.
	assign coef_ok = (int'(fsel_s1) < NUM_FILTERS) && (int'(trow_s1) < FILTER_ROWS) &&
		(int'(tcol_s1) < FILTER_COLS);
	assign s2_last = kind_s2 != TOK_FILT || filt_s2 == FIW'(NUM_FILTERS - 1);
	assign s2_done = valid_s2 && (kind_s2 == TOK_NONE || (adv && s2_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			kind_s2 <= TOK_NONE;
			filt_s2 <= '0;
		end else if (s1_go) begin
			valid_s2 <= 1'b1;
			filt_s2 <= '0;
			if (op_s1 == OP_PIXEL) begin
				kind_s2 <= emit_s1 ? TOK_FILT : TOK_NONE;
			end else begin
				kind_s2 <= coef_ok ? TOK_COEF : TOK_NONE;
			end
		end else if (s2_done) begin
			valid_s2 <= 1'b0;
		end else if (adv && valid_s2 && kind_s2 == TOK_FILT) begin
			filt_s2 <= filt_s2 + FIW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			orow_s2 <= orow_s1;
			ocol_s2 <= ocol_s1;
			cfilt_s2 <= FILT_IDX_W'(fsel_s1);
			ctap_s2 <= TAP_IDX_W'(trow_s1) * TAP_IDX_W'(FILTER_COLS) + TAP_IDX_W'(tcol_s1);
			cval_s2 <= coef_s1;
			if (op_s1 == OP_PIXEL) begin
				for (int r = 0; r < FILTER_ROWS; r++) begin
					for (int c = 0; c < FILTER_COLS; c++) begin
						if (c == FILTER_COLS - 1) begin
							win_s2[r*FILTER_COLS+c] <= col_vec[r*PIX_W +: PIX_W];
						end else begin
							win_s2[r*FILTER_COLS+c] <= win_s2[r*FILTER_COLS+c+1];
						end
					end
				end
			end
		end
	end

	always_comb begin
		inj_ctl.kind = valid_s2 ? kind_s2 : TOK_NONE;
		inj_ctl.filt = (kind_s2 == TOK_COEF) ? cfilt_s2 : FILT_IDX_W'(filt_s2);
		inj_ctl.tap = ctap_s2;
		inj_ctl.last = filt_s2 == FIW'(NUM_FILTERS - 1);
	end

	// Tap chain.
	assign adv = !out_valid_q || out_ch.ready;

	assign ctl_c[0] = inj_ctl;
	assign win_c[0] = win_s2;
	assign psum_c[0] = '0;
	assign orow_c[0] = orow_s2;
	assign ocol_c[0] = ocol_s2;
	assign coefv_c[0] = cval_s2;

	generate
		for (genvar k = 0; k < TAPS; k++) begin : g_cell
			c2dfb_cell #(
				.NUM_FILTERS(NUM_FILTERS),
				.TAP(k),
				.TAPS(TAPS)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.en(adv),
				.prev_ctl(ctl_c[k]),
				.prev_win(win_c[k]),
				.prev_psum(psum_c[k]),
				.prev_orow(orow_c[k]),
				.prev_ocol(ocol_c[k]),
				.prev_coef(coefv_c[k]),
				.next_ctl(ctl_c[k+1]),
				.next_win(win_c[k+1]),
				.next_psum(psum_c[k+1]),
				.next_orow(orow_c[k+1]),
				.next_ocol(ocol_c[k+1]),
				.next_coef(coefv_c[k+1])
			);
		end
	endgenerate

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctl_c[TAPS].kind == TOK_FILT;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_filt_q <= ctl_c[TAPS].filt[FILT_OUT_W-1:0];
			out_row_q <= orow_c[TAPS];
			out_col_q <= ocol_c[TAPS];
			out_resp_q <= psum_c[TAPS];
			out_last_q <= ctl_c[TAPS].last;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.filter_index = out_filt_q;
	assign out_ch.out_row = out_row_q;
	assign out_ch.out_col = out_col_q;
	assign out_ch.response = out_resp_q;
	assign out_ch.last = out_last_q;

	`C2DFB_ASSERT(a_last_is_top_filter, clk, arst_n, out_valid_q && out_last_q, out_filt_q == FILT_OUT_W'(NUM_FILTERS - 1))
	`C2DFB_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_acc, valid_s1)
	`C2DFB_ASSERT(a_col_in_width, clk, arst_n, 1'b1, WW'(col_q) < w_eff)
	`C2DFB_ASSERT(a_filt_cnt_range, clk, arst_n, valid_s2, int'(filt_s2) < NUM_FILTERS)
endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the strided 3x3 filter bank: directed rows, then random frames.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import c2dfb_pkg::*;

	localparam int N_FILT = 4;
	localparam int TAP_ROWS = 3;
	localparam int TAP_COLS = 3;
	localparam int TAPS = TAP_ROWS * TAP_COLS;
	localparam int LINE_LEN = 1024;
	localparam int DRAIN_CYCLES = 2 * (TAPS + 3);
	localparam int QUIET_LIMIT = 2000;
	localparam int MAX_REPORTS = 100;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum logic {
		ROW_REG,
		ROW_ITEM
	} row_kind_e;

	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_e;

	typedef struct packed {
		logic op;
		logic [FILT_SEL_W-1:0] filter_sel;
		logic [TAP_SEL_W-1:0] tap_row;
		logic [TAP_SEL_W-1:0] tap_col;
		coef_t coefficient;
		logic [PIX_W-1:0] pixel;
	} item_t;

	typedef struct packed {
		logic [FILT_OUT_W-1:0] filt;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		resp_t resp;
		logic last;
	} result_t;

	typedef struct packed {
		row_kind_e kind;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CFG_W-1:0] reg_data;
		item_t it;
		logic typed;
		logic [POS_W-1:0] exp_row;
		logic [POS_W-1:0] exp_col;
		resp_t [N_FILT-1:0] exp_resp;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	c2dfb_in_if in_ch ();
	c2dfb_out_if out_ch ();

	conv2d_filter_bank_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;
	logic [STRIDE_W-1:0] stride_reg;
	coef_t coef_mem [N_FILT][TAPS];
	logic [PIX_W-1:0] line_mem [TAP_ROWS-1][LINE_LEN];
	logic [PIX_W-1:0] win [TAP_ROWS][TAP_COLS];
	int unsigned col_cnt;
	int unsigned row_cnt;
	result_t fresh [N_FILT];

	result_t pending_responses[$];
	stim_row_t directed_rows[$];
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int mismatch_cnt;
	int quiet_cycles;

	task automatic report_mismatch(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTS) begin
			$display("%0t ns: %s", $time, msg);
		end
	endtask

	function automatic int convolve_item(input item_t it);
		int unsigned w;
		int unsigned h;
		int unsigned s;
		int unsigned c;
		int unsigned r;
		int acc;
		logic [PIX_W-1:0] column [TAP_ROWS];
		if (it.op == OP_COEF) begin
			if (int'(it.tap_row) < TAP_ROWS && int'(it.tap_col) < TAP_COLS
					&& int'(it.filter_sel) < N_FILT) begin
				coef_mem[it.filter_sel][int'(it.tap_row) * TAP_COLS + int'(it.tap_col)] =
					it.coefficient;
			end
			return 0;
		end
		w = (width_reg == '0) ? 1 : ((int'(width_reg) > LINE_LEN) ? LINE_LEN : int'(width_reg));
		h = (height_reg == '0) ? 1 :
			((int'(height_reg) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg));
		s = (stride_reg == '0) ? 1 : int'(stride_reg);
		c = (col_cnt >= w) ? 0 : col_cnt;
		r = (row_cnt >= h) ? 0 : row_cnt;

		for (int k = 0; k < TAP_ROWS - 1; k++) begin
			column[k] = line_mem[k][c];
		end
		column[TAP_ROWS-1] = it.pixel;
		for (int k = 0; k < TAP_ROWS - 1; k++) begin
			line_mem[k][c] = column[k+1];
		end
		for (int k = 0; k < TAP_ROWS; k++) begin
			for (int j = 0; j < TAP_COLS - 1; j++) begin
				win[k][j] = win[k][j+1];
			end
			win[k][TAP_COLS-1] = column[k];
		end

		convolve_item = 0;
		if (r >= TAP_ROWS - 1 && c >= TAP_COLS - 1
				&& (r - (TAP_ROWS - 1)) % s == 0 && (c - (TAP_COLS - 1)) % s == 0) begin
			for (int f = 0; f < N_FILT; f++) begin
				acc = 0;
				for (int k = 0; k < TAP_ROWS; k++) begin
					for (int j = 0; j < TAP_COLS; j++) begin
						acc += int'(win[k][j]) * int'(coef_mem[f][k * TAP_COLS + j]);
					end
				end
				fresh[f].filt = FILT_OUT_W'(f);
				fresh[f].row = POS_W'((r - (TAP_ROWS - 1)) / s);
				fresh[f].col = POS_W'((c - (TAP_COLS - 1)) / s);
				fresh[f].resp = resp_t'(acc);
				fresh[f].last = (f == N_FILT - 1);
			end
			convolve_item = N_FILT;
		end

		if (c + 1 >= w) begin
			c = 0;
			r = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			c++;
		end
		col_cnt = c;
		row_cnt = r;
	endfunction

	task automatic feed(input item_t it, input logic typed, input logic [POS_W-1:0] er,
			input logic [POS_W-1:0] ec, input resp_t [N_FILT-1:0] eresp);
		int cnt;
		result_t tmp;
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= it.op;
		in_ch.filter_sel <= it.filter_sel;
		in_ch.tap_row <= it.tap_row;
		in_ch.tap_col <= it.tap_col;
		in_ch.coefficient <= it.coefficient;
		in_ch.pixel <= it.pixel;
		do begin
			@(posedge clk);
		end while (in_ch.ready !== 1'b1);

		cnt = convolve_item(it);
		if (typed) begin
			cnt = N_FILT;
		end
		for (int f = 0; f < cnt; f++) begin
			tmp = fresh[f];
			if (typed) begin
				tmp.filt = FILT_OUT_W'(f);
				tmp.row = er;
				tmp.col = ec;
				tmp.resp = eresp[f];
				tmp.last = (f == N_FILT - 1);
			end
			pending_responses.push_back(tmp);
		end
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (pending_responses.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH: width_reg = data;
			REG_IMAGE_HEIGHT: height_reg = data;
			REG_STRIDE: stride_reg = data[STRIDE_W-1:0];
			default: ;
		endcase
		if (idx != REG_UNUSED) begin
			col_cnt = 0;
			row_cnt = 0;
		end
		@(posedge clk);
	endtask

	task automatic run_phase(input int w, input int h, input int s, input int n,
			input int unsigned coef_pct, input idle_mode_e mode, input bit poke_unused);
		item_t it;
		wait_drained();
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SEND: begin
				send_idle_pct = 71;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct = 0;
				recv_stall_pct = 71;
			end
			default: begin
				send_idle_pct = 38;
				recv_stall_pct = 38;
			end
		endcase
		write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
		write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
		write_reg(REG_STRIDE, CFG_W'(s));
		for (int i = 0; i < n; i++) begin
			if (poke_unused && i == n / 2) begin
				wait_drained();
				write_reg(REG_UNUSED, CFG_W'($urandom));
			end
			it.op = ($urandom_range(99) < coef_pct) ? OP_COEF : OP_PIXEL;
			it.filter_sel = FILT_SEL_W'($urandom);
			it.tap_row = ($urandom_range(7) == 0) ? TAP_SEL_W'(3) : TAP_SEL_W'($urandom_range(2));
			it.tap_col = ($urandom_range(7) == 0) ? TAP_SEL_W'(3) : TAP_SEL_W'($urandom_range(2));
			it.coefficient = coef_t'($urandom);
			it.pixel = PIX_W'($urandom);
			feed(it, 1'b0, '0, '0, '0);
		end
	endtask

	function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int data);
		stim_row_t row;
		row = '0;
		row.kind = ROW_REG;
		row.reg_idx = idx;
		row.reg_data = CFG_W'(data);
		return row;
	endfunction

	function automatic stim_row_t coef_row(input int f, input int tr, input int tc, input int v);
		stim_row_t row;
		row = '0;
		row.kind = ROW_ITEM;
		row.it.op = OP_COEF;
		row.it.filter_sel = FILT_SEL_W'(f);
		row.it.tap_row = TAP_SEL_W'(tr);
		row.it.tap_col = TAP_SEL_W'(tc);
		row.it.coefficient = coef_t'(v);
		return row;
	endfunction

	function automatic stim_row_t pix_row(input logic [PIX_W-1:0] p);
		stim_row_t row;
		row = '0;
		row.kind = ROW_ITEM;
		row.it.op = OP_PIXEL;
		row.it.pixel = p;
		return row;
	endfunction

	function automatic stim_row_t pix_row_exp(input logic [PIX_W-1:0] p, input int er,
			input int ec, input resp_t [N_FILT-1:0] eresp);
		stim_row_t row;
		row = pix_row(p);
		row.typed = 1'b1;
		row.exp_row = POS_W'(er);
		row.exp_col = POS_W'(ec);
		row.exp_resp = eresp;
		return row;
	endfunction

	always @(posedge clk) begin : result_sink
		result_t got;
		result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.filt = out_ch.filter_index;
			got.row = out_ch.out_row;
			got.col = out_ch.out_col;
			got.resp = out_ch.response;
			got.last = out_ch.last;
			if (pending_responses.size() == 0) begin
				report_mismatch($sformatf("unexpected result: filter %0d row %0d col %0d resp %0d",
					got.filt, got.row, got.col, got.resp));
			end else begin
				want = pending_responses.pop_front();
				if (got.filt !== want.filt)
					report_mismatch($sformatf("filter_index %0d, expected %0d",
						got.filt, want.filt));
				if (got.row !== want.row)
					report_mismatch($sformatf("filter %0d: out_row %0d, expected %0d",
						want.filt, got.row, want.row));
				if (got.col !== want.col)
					report_mismatch($sformatf("filter %0d: out_col %0d, expected %0d",
						want.filt, got.col, want.col));
				if (got.resp !== want.resp)
					report_mismatch($sformatf("filter %0d row %0d col %0d: response %0d, expected %0d",
						want.filt, want.row, want.col, got.resp, want.resp));
				if (got.last !== want.last)
					report_mismatch($sformatf("filter %0d row %0d col %0d: last %0b, expected %0b",
						want.filt, want.row, want.col, got.last, want.last));
			end
		end
		out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_wr_en) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.op = OP_COEF;
		in_ch.filter_sel = '0;
		in_ch.tap_row = '0;
		in_ch.tap_col = '0;
		in_ch.coefficient = '0;
		in_ch.pixel = '0;
		out_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatch_cnt = 0;
		quiet_cycles = 0;

		width_reg = CFG_W'(IMAGE_WIDTH_RESET);
		height_reg = CFG_W'(IMAGE_HEIGHT_RESET);
		stride_reg = STRIDE_W'(STRIDE_RESET);
		col_cnt = 0;
		row_cnt = 0;
		foreach (coef_mem[f, t]) coef_mem[f][t] = '0;
		foreach (line_mem[k, c]) line_mem[k][c] = '0;
		foreach (win[k, j]) win[k][j] = '0;

		// A 3x3 frame of full-scale pixels against the extreme coefficients, where the
		// out-of-range tap writes would land in filters 1 and 2 if they were not dropped.
		directed_rows.push_back(cfg_row(REG_IMAGE_WIDTH, 3));
		directed_rows.push_back(cfg_row(REG_IMAGE_HEIGHT, 3));
		directed_rows.push_back(cfg_row(REG_STRIDE, 1));
		directed_rows.push_back(coef_row(0, 0, 0, 32767));
		directed_rows.push_back(coef_row(3, 2, 2, -32768));
		directed_rows.push_back(coef_row(1, 3, 0, 'h1234));
		directed_rows.push_back(coef_row(2, 0, 3, 'h4321));
		repeat (8) directed_rows.push_back(pix_row(8'd255));
		directed_rows.push_back(pix_row_exp(8'd255, 0, 0,
			{resp_t'(-8355840), resp_t'(0), resp_t'(0), resp_t'(8355585)}));
		repeat (8) directed_rows.push_back(pix_row(8'd0));
		directed_rows.push_back(pix_row_exp(8'd0, 0, 0, '0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_REG) begin
				wait_drained();
				write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
			end else begin
				feed(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].exp_row,
					directed_rows[i].exp_col, directed_rows[i].exp_resp);
			end
		end

		run_phase(5, 4, 1, 24, 15, IDLE_NONE, 1'b1);
		run_phase(7, 6, 2, 30, 10, IDLE_SEND, 1'b0);
		run_phase(0, 5, 1, 5, 20, IDLE_RECV, 1'b0);
		run_phase(2, 5, 1, 5, 20, IDLE_BOTH, 1'b0);
		run_phase(4, 0, 1, 5, 20, IDLE_NONE, 1'b0);
		run_phase(4, 2, 1, 5, 20, IDLE_SEND, 1'b0);
		run_phase(6, 2047, 0, 24, 10, IDLE_RECV, 1'b0);
		run_phase(9, 9, 15, 24, 5, IDLE_BOTH, 1'b0);
		run_phase(3, 3, 3, 12, 10, IDLE_NONE, 1'b0);
		run_phase(2047, 3, 8, 2060, 0, IDLE_BOTH, 1'b0);
		run_phase(5, 5, 1, 30, 10, IDLE_RECV, 1'b0);

		wait_drained();
		if (mismatch_cnt == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
